FILE: src/hscm_pkg.sv
// Shared types, codes and sizing constants for the heap/stack cell manager.
// Used by hscm_ctrl, hscm_dp and heap_stack_cell_manager.
package hscm_pkg;

  localparam int MEM_CELLS   = 4096;
  localparam int GUARD_CELLS = 16;
  localparam int CELL_BYTES  = 4;
  localparam int MARGIN_BYTES = GUARD_CELLS * CELL_BYTES;
  localparam int IDX_W       = $clog2(MEM_CELLS);

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_POP     = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_PUSH    = 3'd3,
    CMD_READ    = 3'd4,
    CMD_WRITE   = 3'd5,
    CMD_RELOAD  = 3'd6,
    CMD_UNUSED  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HEAP_LOW  = 2'd1,
    ST_STACK_LOW = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_HEAP_BASE    = 2'd0,
    CFG_STACK_TOP    = 2'd1,
    CFG_MEMORY_BYTES = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;  // capture the command beat
    logic exec;   // checks, pointer updates, memory write or read issue
    logic fin;    // finish a command that needed a cell read
  } dp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read;  // command in exec continues after a cell read
  } dp_stat_t;

  // Byte address to cell index: word addressing, wraps onto the store.
  function automatic logic [IDX_W-1:0] cell_idx(input logic [14:0] byte_addr);
    cell_idx = IDX_W'(byte_addr >> 2);
  endfunction

endpackage

FILE: src/hscm_ctrl.sv
// Command sequencer for the heap/stack cell manager.
// Depends on hscm_pkg for the control and status structs.
module hscm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output hscm_pkg::dp_ctl_t  ctl,
  input  hscm_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.need_read) begin
          state_nxt = S_FIN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FIN: begin
        ctl.fin       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: src/hscm_dp.sv
// Datapath of the heap/stack cell manager: registers, pointers, checks, cell store.
// Depends on hscm_pkg; sequenced by hscm_ctrl through dp_ctl_t.
module hscm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  hscm_pkg::dp_ctl_t  ctl,
  output hscm_pkg::dp_stat_t stat,
  input  logic [2:0]         in_cmd,
  input  logic [12:0]        in_cell_count,
  input  logic [13:0]        in_address,
  input  logic signed [31:0] in_data_value,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output logic [1:0]         out_status,
  output logic [13:0]        out_block_address,
  output logic signed [31:0] out_read_data,
  output logic [14:0]        out_heap_pointer,
  output logic [14:0]        out_stack_pointer,
  output logic [12:0]        out_pushed_cells
);

  localparam int IW = hscm_pkg::IDX_W;

  // configuration
  logic [13:0] heap_base_r;
  logic [14:0] stack_top_r;
  logic [14:0] mem_bytes_r;

  // architectural state
  logic [14:0] hp_r, hp_nxt;
  logic [14:0] sp_r, sp_nxt;
  logic [12:0] cnt_r, cnt_nxt;

  // latched command
  hscm_pkg::cmd_t cmd_r;
  logic [12:0]    cells_r;
  logic [13:0]    addr_r;
  logic [31:0]    data_r;

  // pop header address kept across the read
  logic [13:0] hdr_addr_r;

  // results
  logic [1:0]  status_r, status_nxt;
  logic [13:0] block_r, block_nxt;
  logic [31:0] rdata_r, rdata_nxt;

  // cell store
  logic [31:0]   mem [hscm_pkg::MEM_CELLS];
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_widx, mem_ridx;
  logic [31:0]   mem_wdata, mem_rd_r;

  // exec-stage checks
  logic [14:0]        base;
  logic [14:0]        addr15, addr_m4;
  logic signed [17:0] room;
  logic               heap_low;
  logic [15:0]        alloc_end;
  logic [14:0]        alloc_block;
  logic               pop_bad, rel_bad, acc_bad, stack_low;
  logic [14:0]        sp_m4;
  logic signed [35:0] expect_hp;

  assign base        = {1'b0, heap_base_r[13:2], 2'b00};
  assign addr15      = {1'b0, addr_r};
  assign addr_m4     = addr15 - 15'(hscm_pkg::CELL_BYTES);
  assign room        = $signed({3'b000, sp_r}) - $signed({3'b000, hp_r})
                     - $signed({3'b000, cells_r, 2'b00});
  assign heap_low    = room < 18'sd64 + 18'(hscm_pkg::MARGIN_BYTES) - 18'sd64;
  assign alloc_block = hp_r + 15'(hscm_pkg::CELL_BYTES);
  assign alloc_end   = {1'b0, alloc_block} + {1'b0, cells_r, 2'b00};
  assign pop_bad     = (addr15 < 15'(hscm_pkg::CELL_BYTES)) || (addr_m4 < base)
                     || (addr_m4 >= sp_r);
  assign rel_bad     = (addr15 < 15'(hscm_pkg::CELL_BYTES)) || (addr15 < base);
  assign acc_bad     = ((addr15 >= hp_r) && (addr15 < sp_r)) || (addr15 >= mem_bytes_r);
  assign sp_m4       = sp_r - 15'(hscm_pkg::CELL_BYTES);
  assign stack_low   = ($signed({2'b00, hp_r}) + $signed(17'(hscm_pkg::MARGIN_BYTES)))
                     > ($signed({2'b00, sp_r}) - 17'sd4);

  // heap pointer the stored header implies for the block being popped
  assign expect_hp = $signed({21'd0, hp_r}) - $signed({{2{mem_rd_r[31]}}, mem_rd_r, 2'b00})
                   - 36'sd4;

  always_comb begin
    hp_nxt         = hp_r;
    sp_nxt         = sp_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    block_nxt      = block_r;
    rdata_nxt      = rdata_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_widx       = hscm_pkg::cell_idx(hp_r);
    mem_ridx       = hscm_pkg::cell_idx(addr15);
    mem_wdata      = data_r;
    stat.need_read = 1'b0;
    if (ctl.exec) begin
      status_nxt = hscm_pkg::ST_OK;
      block_nxt  = '0;
      rdata_nxt  = '0;
      case (cmd_r)
        hscm_pkg::CMD_ALLOC: begin
          if (heap_low) begin
            status_nxt = hscm_pkg::ST_HEAP_LOW;
          end else begin
            mem_we    = 1'b1;
            mem_widx  = hscm_pkg::cell_idx(hp_r);
            mem_wdata = {19'd0, cells_r};
            block_nxt = alloc_block[13:0];
            hp_nxt    = alloc_end[14:0];
          end
        end
        hscm_pkg::CMD_POP: begin
          if (pop_bad) begin
            status_nxt = hscm_pkg::ST_BAD_ADDR;
          end else begin
            mem_re         = 1'b1;
            mem_ridx       = hscm_pkg::cell_idx(addr_m4);
            stat.need_read = 1'b1;
          end
        end
        hscm_pkg::CMD_RELEASE: begin
          if (rel_bad) begin
            status_nxt = hscm_pkg::ST_BAD_ADDR;
          end else begin
            hp_nxt = addr_m4;
          end
        end
        hscm_pkg::CMD_PUSH: begin
          if (stack_low) begin
            status_nxt = hscm_pkg::ST_STACK_LOW;
          end else begin
            sp_nxt    = sp_m4;
            mem_we    = 1'b1;
            mem_widx  = hscm_pkg::cell_idx(sp_m4);
            mem_wdata = data_r;
            if (cnt_r != 13'h1FFF) begin
              cnt_nxt = cnt_r + 13'd1;
            end
          end
        end
        hscm_pkg::CMD_READ: begin
          if (acc_bad) begin
            status_nxt = hscm_pkg::ST_BAD_ADDR;
          end else begin
            mem_re         = 1'b1;
            mem_ridx       = hscm_pkg::cell_idx(addr15);
            stat.need_read = 1'b1;
          end
        end
        hscm_pkg::CMD_WRITE: begin
          if (acc_bad) begin
            status_nxt = hscm_pkg::ST_BAD_ADDR;
          end else begin
            mem_we    = 1'b1;
            mem_widx  = hscm_pkg::cell_idx(addr15);
            mem_wdata = data_r;
          end
        end
        hscm_pkg::CMD_RELOAD: begin
          hp_nxt  = base;
          sp_nxt  = {stack_top_r[14:2], 2'b00};
          cnt_nxt = '0;
        end
        default: begin
          status_nxt = hscm_pkg::ST_BAD_ADDR;
        end
      endcase
    end else if (ctl.fin) begin
      if (cmd_r == hscm_pkg::CMD_POP) begin
        if (expect_hp != $signed({22'd0, hdr_addr_r})) begin
          status_nxt = hscm_pkg::ST_BAD_ADDR;
        end else begin
          hp_nxt = {1'b0, hdr_addr_r};
        end
      end else begin
        rdata_nxt = mem_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= 14'd4096;
      stack_top_r <= 15'd16384;
      mem_bytes_r <= 15'd16384;
      hp_r        <= 15'd4096;
      sp_r        <= 15'd16384;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (hscm_pkg::cfg_idx_t'(cfg_index))
          hscm_pkg::CFG_HEAP_BASE:    heap_base_r <= cfg_data[13:0];
          hscm_pkg::CFG_STACK_TOP:    stack_top_r <= cfg_data;
          hscm_pkg::CFG_MEMORY_BYTES: mem_bytes_r <= cfg_data;
          default: ;
        endcase
      end
      hp_r  <= hp_nxt;
      sp_r  <= sp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= hscm_pkg::cmd_t'(in_cmd);
      cells_r <= in_cell_count;
      addr_r  <= {in_address[13:2], 2'b00};
      data_r  <= in_data_value;
    end
    if (ctl.exec) begin
      hdr_addr_r <= addr_m4[13:0];
    end
    status_r <= status_nxt;
    block_r  <= block_nxt;
    rdata_r  <= rdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ridx];
    end
  end

  assign out_status        = status_r;
  assign out_block_address = block_r;
  assign out_read_data     = rdata_r;
  assign out_heap_pointer  = hp_r;
  assign out_stack_pointer = sp_r;
  assign out_pushed_cells  = cnt_r;

endmodule

FILE: src/heap_stack_cell_manager.sv
// Top level of the heap/stack cell manager: sequencer plus datapath.
// Depends on hscm_pkg, hscm_ctrl and hscm_dp.
//
// A command is taken when start is high and busy is low. Alloc, release, push,
// write, reload, the unused code and any pop or read that fails its address
// check finish after the exec state; a pop or read that passes its address
// check also goes through fin, for the registered cell store read of the header
// cell for pop or the addressed cell for read. The result appears for exactly
// one cycle with out_valid high and cannot be held off; heap, stack and count
// outputs stay stable through that cycle, and the next command may be started
// in it. Configuration writes are always ready and belong in idle time. The
// cell store is not cleared by reset: reading a cell never written returns junk.
module heap_stack_cell_manager (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [12:0]        in_cell_count,
  input  logic [13:0]        in_address,
  input  logic signed [31:0] in_data_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [13:0]        out_block_address,
  output logic signed [31:0] out_read_data,
  output logic [14:0]        out_heap_pointer,
  output logic [14:0]        out_stack_pointer,
  output logic [12:0]        out_pushed_cells,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  hscm_pkg::dp_ctl_t  ctl;
  hscm_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  hscm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl),
    .stat      (stat)
  );

  hscm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .in_cmd            (in_cmd),
    .in_cell_count     (in_cell_count),
    .in_address        (in_address),
    .in_data_value     (in_data_value),
    .cfg_wr            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_read_data     (out_read_data),
    .out_heap_pointer  (out_heap_pointer),
    .out_stack_pointer (out_stack_pointer),
    .out_pushed_cells  (out_pushed_cells)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_heap_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heap_pointer[1:0] == 2'b00))
    else $error("heap pointer lost word alignment");

  a_block_on_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != hscm_pkg::ST_OK)) |->
      ((out_block_address == '0) && (out_read_data == '0)))
    else $error("failed command returned an address or data");

endmodule

FILE: sim/heap_stack_cell_manager_tb.sv
// Self-checking testbench for heap_stack_cell_manager: directed and random command
// beats against a cycle-free predictor of the heap, stack and cell store.
// Depends on hscm_pkg and the heap_stack_cell_manager RTL.
module heap_stack_cell_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hscm_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] block;
    logic [31:0] rdata;
    logic [14:0] heap;
    logic [14:0] stack;
    logic [12:0] pushed;
  } cell_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_cmd;
  logic [12:0]        in_cell_count;
  logic [13:0]        in_address;
  logic signed [31:0] in_data_value;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [13:0]        out_block_address;
  logic signed [31:0] out_read_data;
  logic [14:0]        out_heap_pointer;
  logic [14:0]        out_stack_pointer;
  logic [12:0]        out_pushed_cells;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [14:0]        cfg_data;

  heap_stack_cell_manager dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_cell_count     (in_cell_count),
    .in_address        (in_address),
    .in_data_value     (in_data_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_read_data     (out_read_data),
    .out_heap_pointer  (out_heap_pointer),
    .out_stack_pointer (out_stack_pointer),
    .out_pushed_cells  (out_pushed_cells),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies and pointer state as the block should hold them
  logic [14:0] heap_base_r    = 15'd4096;
  logic [14:0] stack_top_r    = 15'd16384;
  logic [14:0] memory_bytes_r = 15'd16384;
  logic [14:0] heap_ptr_q     = 15'd4096;
  logic [14:0] stack_ptr_q    = 15'd16384;
  logic [12:0] push_count_q   = 13'd0;
  logic [31:0] cell_mem [0:MEM_CELLS-1];
  bit          cell_written [0:MEM_CELLS-1];
  logic [11:0] written_slots [$];
  logic [13:0] alloc_blocks [$];

  cell_result_t results_due [$];
  int           failures;
  int           results_checked;
  int           beats_sent;
  int           cycle_count;
  int           status_tally [0:3];
  bit           calm;

  function automatic logic [11:0] slot_of(input longint byte_addr);
    return byte_addr[13:2];
  endfunction

  function automatic void store_cell(input longint byte_addr, input logic [31:0] v);
    logic [11:0] s;
    s = slot_of(byte_addr);
    cell_mem[s] = v;
    if (!cell_written[s]) begin
      cell_written[s] = 1'b1;
      written_slots.push_back(s);
    end
  endfunction

  // Advance the pointer state by one command and return the result it must produce
  function automatic cell_result_t apply_command(input cmd_t c, input logic [12:0] cnt,
                                                 input logic [13:0] addr_in,
                                                 input logic [31:0] data);
    cell_result_t r;
    longint hp, sp, a, b, mb, n, hdr, room;
    int h32;
    hp = heap_ptr_q;
    sp = stack_ptr_q;
    a = addr_in & 14'h3FFC;
    b = heap_base_r[13:0] & 14'h3FFC;
    mb = memory_bytes_r;
    n = cnt;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_ALLOC: begin
        room = sp - hp - 4 * n;
        if (room < MARGIN_BYTES) begin
          r.status = ST_HEAP_LOW;
        end else begin
          store_cell(hp, {19'd0, cnt});
          r.block = 14'(hp + 4);
          heap_ptr_q = 15'(hp + 4 + 4 * n);
        end
      end
      CMD_POP: begin
        if (a < 4 || a - 4 < b || a - 4 >= sp) begin
          r.status = ST_BAD_ADDR;
        end else begin
          h32 = cell_mem[slot_of(a - 4)];
          hdr = h32;
          if (hp - 4 * hdr - 4 != a - 4) r.status = ST_BAD_ADDR;
          else heap_ptr_q = 15'(a - 4);
        end
      end
      CMD_RELEASE: begin
        if (a < 4 || a < b) r.status = ST_BAD_ADDR;
        else heap_ptr_q = 15'(a - 4);
      end
      CMD_PUSH: begin
        if (hp + MARGIN_BYTES > sp - 4) begin
          r.status = ST_STACK_LOW;
        end else begin
          stack_ptr_q = 15'(sp - 4);
          store_cell(sp - 4, data);
          if (push_count_q != 13'h1FFF) push_count_q = push_count_q + 13'd1;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if ((a >= hp && a < sp) || a >= mb) r.status = ST_BAD_ADDR;
        else if (c == CMD_READ) r.rdata = cell_mem[slot_of(a)];
        else store_cell(a, data);
      end
      CMD_RELOAD: begin
        heap_ptr_q = 15'(b);
        stack_ptr_q = stack_top_r & 15'h7FFC;
        push_count_q = '0;
      end
      default: r.status = ST_BAD_ADDR;
    endcase
    r.heap = heap_ptr_q;
    r.stack = stack_ptr_q;
    r.pushed = push_count_q;
    return r;
  endfunction

  // Send one command beat after a random gap (none in calm mode); returns at the accepting edge
  task automatic send_cmd(input cmd_t c, input logic [12:0] cnt, input logic [13:0] addr,
                          input logic [31:0] data);
    cmd_t eff;
    longint pa;
    int gap;
    cell_result_t r;
    eff = c;
    pa = addr & 14'h3FFC;
    pa = pa - 4;
    // never let the block read a cell that holds nothing yet
    if (eff == CMD_POP && !cell_written[slot_of(pa)]) eff = CMD_RELEASE;
    if (eff == CMD_READ && !cell_written[addr[13:2]]) eff = CMD_WRITE;
    gap = calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_cmd <= eff;
    in_cell_count <= cnt;
    in_address <= addr;
    in_data_value <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_command(eff, cnt, addr, data);
    results_due.push_back(r);
    status_tally[r.status]++;
    beats_sent++;
    if (eff == CMD_RELOAD) alloc_blocks.delete();
    if (eff == CMD_ALLOC && r.status == ST_OK) alloc_blocks.push_back(r.block);
    // drop blocks whose header now lies at or above the heap pointer
    while (alloc_blocks.size() > 0 && int'(alloc_blocks[$]) - 4 >= int'(heap_ptr_q))
      void'(alloc_blocks.pop_back());
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [14:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HEAP_BASE:    heap_base_r = {1'b0, val[13:0]};
      CFG_STACK_TOP:    stack_top_r = val;
      CFG_MEMORY_BYTES: memory_bytes_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [14:0] hb, input logic [14:0] st, input logic [14:0] mb);
    settle();
    write_reg(CFG_HEAP_BASE, hb);
    write_reg(CFG_STACK_TOP, st);
    write_reg(CFG_MEMORY_BYTES, mb);
    send_cmd(CMD_RELOAD, 13'($urandom), 14'($urandom), $urandom);
  endtask

  task automatic random_beat();
    int pick, sel;
    longint room, hb;
    logic [12:0] n;
    logic [13:0] a;
    logic [31:0] d;
    cmd_t c;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    n = 13'($urandom_range(0, 24));
    a = 14'($urandom);
    d = $urandom;
    hb = heap_base_r[13:0] & 14'h3FFC;
    if (pick < 22) begin
      c = CMD_ALLOC;
      room = stack_ptr_q;
      room = room - heap_ptr_q - MARGIN_BYTES;
      // aim at the exact room boundary now and then
      if (sel < 6 && room >= 0) n = 13'(room / 4 + $urandom_range(0, 1));
      else if (sel < 18) n = 13'($urandom);
    end else if (pick < 40) begin
      c = CMD_POP;
      if (alloc_blocks.size() > 0 && sel < 70)
        a = alloc_blocks[$] + 14'($urandom_range(0, 3));
      else if (alloc_blocks.size() > 0 && sel < 85)
        a = alloc_blocks[$urandom_range(0, alloc_blocks.size() - 1)] + 14'd4;
    end else if (pick < 45) begin
      c = CMD_RELEASE;
      if (alloc_blocks.size() > 0 && sel < 50) a = alloc_blocks[$];
    end else if (pick < 65) begin
      c = CMD_PUSH;
    end else if (pick < 80) begin
      c = CMD_READ;
      if (written_slots.size() > 0 && sel < 75)
        a = {written_slots[$urandom_range(0, written_slots.size() - 1)],
             2'($urandom_range(0, 3))};
    end else if (pick < 95) begin
      c = CMD_WRITE;
      if (sel < 40 && heap_ptr_q > hb)
        a = 14'($urandom_range(int'(hb), int'(heap_ptr_q) - 1));
      else if (sel < 70 && written_slots.size() > 0)
        a = {written_slots[$urandom_range(0, written_slots.size() - 1)],
             2'($urandom_range(0, 3))};
    end else if (pick < 98) begin
      c = CMD_RELOAD;
    end else begin
      c = CMD_UNUSED;
    end
    send_cmd(c, n, a, d);
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      // switch between back-to-back beats and random gaps
      if (i % 50 == 0) calm = ($urandom_range(0, 99) < 30);
      random_beat();
    end
    calm = 1'b0;
  endtask

  task automatic test_defaults_directed();
    send_cmd(CMD_PUSH, 13'h1FFF, 14'h3FFF, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH, 13'd0, 14'd0, 32'h8000_0000);
    send_cmd(CMD_ALLOC, 13'd0, 14'd0, 32'd0);
    send_cmd(CMD_ALLOC, 13'd3, 14'h3FFF, 32'hFFFF_FFFF);
    send_cmd(CMD_WRITE, 13'd0, 14'd4104, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 13'd0, 14'd4107, 32'd0);
    send_cmd(CMD_READ, 13'd0, 14'd16380, 32'd0);
    send_cmd(CMD_WRITE, 13'd0, 14'd8000, 32'h1234_5678);
    send_cmd(CMD_ALLOC, 13'd4096, 14'd0, 32'd0);
    send_cmd(CMD_ALLOC, 13'h1FFF, 14'd0, 32'd0);
    send_cmd(CMD_POP, 13'd0, 14'd4104, 32'd0);
    send_cmd(CMD_POP, 13'd0, 14'd4104, 32'd0);
    send_cmd(CMD_POP, 13'd0, 14'd4100, 32'd0);
    send_cmd(CMD_POP, 13'd0, 14'd0, 32'd0);
    send_cmd(CMD_WRITE, 13'd0, 14'd4092, 32'd0);
    send_cmd(CMD_POP, 13'd0, 14'd4096, 32'd0);
    send_cmd(CMD_POP, 13'd0, 14'h3FFF, 32'd0);
    send_cmd(CMD_RELEASE, 13'd0, 14'd4104, 32'd0);
    send_cmd(CMD_READ, 13'd0, 14'd4104, 32'd0);
    send_cmd(CMD_RELEASE, 13'd0, 14'd2, 32'd0);
    send_cmd(CMD_RELEASE, 13'd0, 14'd4092, 32'd0);
    send_cmd(CMD_WRITE, 13'd0, 14'h3FFF, 32'd1);
    send_cmd(CMD_UNUSED, 13'h1FFF, 14'h3FFF, 32'hFFFF_FFFF);
    send_cmd(CMD_RELOAD, 13'd0, 14'd0, 32'd0);
    send_cmd(CMD_PUSH, 13'd0, 14'd0, 32'd0);
    random_run(300);
  endtask

  task automatic test_wide_heap();
    configure(15'd0, 15'd16384, 15'd16384);
    random_run(300);
  endtask

  task automatic test_inverted_limits();
    configure(15'd16380, 15'd0, 15'd0);
    random_run(150);
  endtask

  task automatic test_tight_window();
    configure(15'd8002, 15'd8403, 15'd12000);
    random_run(300);
  endtask

  task automatic test_oversized_memory();
    configure(15'd1024, 15'd16383, 15'h7FFF);
    // drop start and drain the reload before touching the registers again
    settle();
    // index with no register behind it must change nothing
    write_reg(CFG_NONE, 15'h2AAA);
    random_run(300);
  endtask

  task automatic test_drain_pause();
    configure(15'd4096, 15'd16384, 15'd16384);
    random_run(150);
    // hold off until every pending result has come back
    settle();
    random_run(150);
  endtask

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result with nothing pending: status %0d heap %0d stack %0d",
                   out_status, out_heap_pointer, out_stack_pointer);
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (out_status !== want.status || out_block_address !== want.block ||
            out_read_data !== want.rdata || out_heap_pointer !== want.heap ||
            out_stack_pointer !== want.stack || out_pushed_cells !== want.pushed) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display({"mismatch on result %0d (expected/actual): status %0d/%0d ",
                      "block %0d/%0d read %h/%h heap %0d/%0d stack %0d/%0d pushed %0d/%0d"},
                     results_checked, want.status, out_status, want.block,
                     out_block_address, want.rdata, out_read_data, want.heap,
                     out_heap_pointer, want.stack, out_stack_pointer, want.pushed,
                     out_pushed_cells);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count,
               results_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_ALLOC;
    in_cell_count = '0;
    in_address = '0;
    in_data_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEAP_BASE;
    cfg_data = '0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults_directed();
    test_wide_heap();
    test_inverted_limits();
    test_tight_window();
    test_oversized_memory();
    test_drain_pause();

    settle();
    failures += results_due.size();
    $display("%0d commands over six register settings: %0d ok, %0d heap low, %0d stack low",
             beats_sent, status_tally[ST_OK], status_tally[ST_HEAP_LOW],
             status_tally[ST_STACK_LOW]);
    $display("%0d invalid address, %0d results checked, %0d failures",
             status_tally[ST_BAD_ADDR], results_checked, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
